@@ hw/rtl/gaeng_pkg.sv @@
// ----------------------------------------------------------------------------
// gaeng_pkg
// Shared widths, item codes and memory control type for the GA generation
// engine.
// ----------------------------------------------------------------------------
package gaeng_pkg;

   localparam int POP    = 16;
   localparam int IDX_W  = 4;
   localparam int GENE_W = 16;
   localparam int FIT_W  = 16;
   localparam int SUM_W  = 20;
   localparam int CUT_W  = 5;
   localparam int DRAW_W = 20;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SELECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CROSS  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MUTATE = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DRAW  = 2'd2;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POP - 1);
   localparam logic [IDX_W-1:0] PAIR_LAST = IDX_W'(POP / 2 - 1);

   typedef struct packed {
      logic              re;
      logic              we;
      logic [IDX_W-1:0]  raddr;
      logic [IDX_W-1:0]  waddr;
      logic [GENE_W-1:0] wdata;
   } mem_ctl_type;

   // ones in every bit position below cut; cut past the genome gives all ones
   function automatic logic [GENE_W-1:0] low_mask(input logic [CUT_W-1:0] cut);
      logic [GENE_W-1:0] m;
      m = '0;
      for (int i = 0; i < GENE_W; i++) begin
         m[i] = (i < int'(cut));
      end
      return m;
   endfunction

endpackage

@@ hw/rtl/roulette_ga_generation_engine_top.sv @@
// ----------------------------------------------------------------------------
// roulette_ga_generation_engine_top
// GA generation engine: load, roulette select, single-point crossover and
// mutate items over genome, parent and fitness stores.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (req_valid/req_ready) carries one item; req_type picks the
//  operation. Each item gives exactly one result on the rsp_ channel.
//  One item is worked on at a time; req_ready is high only while idle.
//  Load reads the old fitness entry, then writes; mutate reads, then writes;
//  crossover reads both parents, then writes each child (an out-of-range pair
//  goes straight to its result); select walks the wheel up to the last entry
//  (0..15) it needs, reading one fitness entry per cycle from the fitness store,
//  then reads the picked genome and writes it to the parent store.
//  The result register lets the next item be accepted and worked on while a
//  result waits; when the receiver stalls, the next item holds in its final
//  step, with no store written, until the result register frees.
//  Synchronous reset clears all stores (through valid bits), the fitness
//  total and the result valid flag; store reads then return zero.
// ----------------------------------------------------------------------------
module roulette_ga_generation_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gaeng_pkg::KIND_W-1:0]  req_type,
   input  logic [gaeng_pkg::IDX_W-1:0]   req_slot_index,
   input  logic [gaeng_pkg::GENE_W-1:0]  req_genome_bits,
   input  logic [gaeng_pkg::FIT_W-1:0]   req_fitness_value,
   input  logic [gaeng_pkg::DRAW_W-1:0]  req_wheel_draw,
   input  logic [gaeng_pkg::CUT_W-1:0]   req_cut_point,
   input  logic [gaeng_pkg::GENE_W-1:0]  req_flip_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gaeng_pkg::IDX_W-1:0]   rsp_picked_index,
   output logic [gaeng_pkg::GENE_W-1:0]  rsp_genome_first,
   output logic [gaeng_pkg::GENE_W-1:0]  rsp_genome_second,
   output logic [gaeng_pkg::SUM_W-1:0]   rsp_fitness_sum,
   output logic [gaeng_pkg::STAT_W-1:0]  rsp_status_code
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_LD_RD    = 4'd1;
   localparam logic [3:0] ST_LD_WR    = 4'd2;
   localparam logic [3:0] ST_SEL_RD   = 4'd3;
   localparam logic [3:0] ST_SEL_WALK = 4'd4;
   localparam logic [3:0] ST_SEL_GEN  = 4'd5;
   localparam logic [3:0] ST_SEL_WR   = 4'd6;
   localparam logic [3:0] ST_XO_RDA   = 4'd7;
   localparam logic [3:0] ST_XO_RDB   = 4'd8;
   localparam logic [3:0] ST_XO_WRA   = 4'd9;
   localparam logic [3:0] ST_XO_WRB   = 4'd10;
   localparam logic [3:0] ST_XO_ERR   = 4'd11;
   localparam logic [3:0] ST_MUT_RD   = 4'd12;
   localparam logic [3:0] ST_MUT_WR   = 4'd13;

   logic [3:0] state_ff, state_in;

   logic [gaeng_pkg::IDX_W-1:0]  slot_ff;
   logic [gaeng_pkg::GENE_W-1:0] gene_ff;
   logic [gaeng_pkg::FIT_W-1:0]  fit_ff;
   logic [gaeng_pkg::DRAW_W-1:0] draw_ff;
   logic [gaeng_pkg::CUT_W-1:0]  cut_ff;
   logic [gaeng_pkg::GENE_W-1:0] mask_ff;

   logic [gaeng_pkg::IDX_W-1:0]  cnt_ff, cnt_in;
   logic [gaeng_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic [gaeng_pkg::IDX_W-1:0]  pick_ff, pick_in;
   logic                         miss_ff, miss_in;
   logic [gaeng_pkg::GENE_W-1:0] pa_ff, pa_in;
   logic [gaeng_pkg::SUM_W-1:0]  total_ff, total_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gaeng_pkg::IDX_W-1:0]   rsp_pick_ff, rsp_pick_in;
   logic [gaeng_pkg::GENE_W-1:0]  rsp_first_ff, rsp_first_in;
   logic [gaeng_pkg::GENE_W-1:0]  rsp_second_ff, rsp_second_in;
   logic [gaeng_pkg::SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [gaeng_pkg::STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;

   gaeng_pkg::mem_ctl_type       gen_ctl, par_ctl, fit_ctl;
   logic [gaeng_pkg::GENE_W-1:0] gen_q, par_q, fit_q;

   logic                         accept;
   logic                         out_free;
   logic [gaeng_pkg::IDX_W-1:0]  pair_a, pair_b;
   logic [gaeng_pkg::GENE_W-1:0] cut_mask, child_a, child_b;
   logic [gaeng_pkg::SUM_W-1:0]  walk_sum, load_total;
   logic                         walk_hit;

   gaeng_store u_genome (.clock(clock), .reset(reset), .ctl(gen_ctl), .rdata(gen_q));
   gaeng_store u_parent (.clock(clock), .reset(reset), .ctl(par_ctl), .rdata(par_q));
   gaeng_store u_fitness (.clock(clock), .reset(reset), .ctl(fit_ctl), .rdata(fit_q));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign pair_a   = {slot_ff[gaeng_pkg::IDX_W-2:0], 1'b0};
   assign pair_b   = {slot_ff[gaeng_pkg::IDX_W-2:0], 1'b1};
   assign cut_mask = gaeng_pkg::low_mask(cut_ff);
   assign child_a  = (pa_ff & cut_mask) | (par_q & ~cut_mask);
   assign child_b  = (par_q & cut_mask) | (pa_ff & ~cut_mask);

   assign walk_sum   = acc_ff + gaeng_pkg::SUM_W'(fit_q);
   assign walk_hit   = (walk_sum >= draw_ff);
   assign load_total = total_ff - gaeng_pkg::SUM_W'(fit_q) + gaeng_pkg::SUM_W'(fit_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      pick_in       = pick_ff;
      miss_in       = miss_ff;
      pa_in         = pa_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pick_in   = rsp_pick_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_stat_in   = rsp_stat_ff;
      gen_ctl       = '0;
      par_ctl       = '0;
      fit_ctl       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  gaeng_pkg::KIND_LOAD:   state_in = ST_LD_RD;
                  gaeng_pkg::KIND_SELECT: state_in = ST_SEL_RD;
                  gaeng_pkg::KIND_CROSS: begin
                     state_in = (req_slot_index > gaeng_pkg::PAIR_LAST) ? ST_XO_ERR
                                                                        : ST_XO_RDA;
                  end
                  default:                state_in = ST_MUT_RD;
               endcase
            end
         end
         ST_LD_RD: begin
            fit_ctl.re    = 1'b1;
            fit_ctl.raddr = slot_ff;
            state_in      = ST_LD_WR;
         end
         ST_LD_WR: begin
            if (out_free) begin
               fit_ctl.we    = 1'b1;
               fit_ctl.waddr = slot_ff;
               fit_ctl.wdata = fit_ff;
               gen_ctl.we    = 1'b1;
               gen_ctl.waddr = slot_ff;
               gen_ctl.wdata = gene_ff;
               total_in      = load_total;
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = '0;
               rsp_first_in  = gene_ff;
               rsp_second_in = '0;
               rsp_sum_in    = load_total;
               rsp_stat_in   = gaeng_pkg::STAT_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_SEL_RD: begin
            fit_ctl.re    = 1'b1;
            fit_ctl.raddr = '0;
            cnt_in        = '0;
            acc_in        = '0;
            state_in      = ST_SEL_WALK;
         end
         ST_SEL_WALK: begin
            if (walk_hit || cnt_ff == gaeng_pkg::LAST_IDX) begin
               pick_in  = cnt_ff;
               miss_in  = !walk_hit;
               state_in = ST_SEL_GEN;
            end else begin
               acc_in        = walk_sum;
               cnt_in        = cnt_ff + 1'b1;
               fit_ctl.re    = 1'b1;
               fit_ctl.raddr = cnt_ff + 1'b1;
            end
         end
         ST_SEL_GEN: begin
            gen_ctl.re    = 1'b1;
            gen_ctl.raddr = pick_ff;
            state_in      = ST_SEL_WR;
         end
         ST_SEL_WR: begin
            if (out_free) begin
               par_ctl.we    = 1'b1;
               par_ctl.waddr = slot_ff;
               par_ctl.wdata = gen_q;
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = pick_ff;
               rsp_first_in  = gen_q;
               rsp_second_in = '0;
               rsp_sum_in    = total_ff;
               rsp_stat_in   = miss_ff ? gaeng_pkg::STAT_DRAW : gaeng_pkg::STAT_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_XO_RDA: begin
            par_ctl.re    = 1'b1;
            par_ctl.raddr = pair_a;
            state_in      = ST_XO_RDB;
         end
         ST_XO_RDB: begin
            pa_in         = par_q;
            par_ctl.re    = 1'b1;
            par_ctl.raddr = pair_b;
            state_in      = ST_XO_WRA;
         end
         ST_XO_WRA: begin
            gen_ctl.we    = 1'b1;
            gen_ctl.waddr = pair_a;
            gen_ctl.wdata = child_a;
            state_in      = ST_XO_WRB;
         end
         ST_XO_WRB: begin
            if (out_free) begin
               gen_ctl.we    = 1'b1;
               gen_ctl.waddr = pair_b;
               gen_ctl.wdata = child_b;
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = '0;
               rsp_first_in  = child_a;
               rsp_second_in = child_b;
               rsp_sum_in    = total_ff;
               rsp_stat_in   = gaeng_pkg::STAT_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_XO_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = '0;
               rsp_first_in  = '0;
               rsp_second_in = '0;
               rsp_sum_in    = total_ff;
               rsp_stat_in   = gaeng_pkg::STAT_RANGE;
               state_in      = ST_IDLE;
            end
         end
         ST_MUT_RD: begin
            gen_ctl.re    = 1'b1;
            gen_ctl.raddr = slot_ff;
            state_in      = ST_MUT_WR;
         end
         ST_MUT_WR: begin
            if (out_free) begin
               gen_ctl.we    = 1'b1;
               gen_ctl.waddr = slot_ff;
               gen_ctl.wdata = gen_q ^ mask_ff;
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = '0;
               rsp_first_in  = gen_q ^ mask_ff;
               rsp_second_in = '0;
               rsp_sum_in    = total_ff;
               rsp_stat_in   = gaeng_pkg::STAT_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= req_slot_index;
         gene_ff <= req_genome_bits;
         fit_ff  <= req_fitness_value;
         draw_ff <= req_wheel_draw;
         cut_ff  <= req_cut_point;
         mask_ff <= req_flip_mask;
      end
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      pick_ff       <= pick_in;
      miss_ff       <= miss_in;
      pa_ff         <= pa_in;
      rsp_pick_ff   <= rsp_pick_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_stat_ff   <= rsp_stat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_picked_index  = rsp_pick_ff;
   assign rsp_genome_first  = rsp_first_ff;
   assign rsp_genome_second = rsp_second_ff;
   assign rsp_fitness_sum   = rsp_sum_ff;
   assign rsp_status_code   = rsp_stat_ff;

endmodule

@@ hw/rtl/gaeng_store.sv @@
// ----------------------------------------------------------------------------
// gaeng_store
// 16 x 16 synchronous store, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module gaeng_store (
   input  logic                          clock,
   input  logic                          reset,
   input  gaeng_pkg::mem_ctl_type        ctl,
   output logic [gaeng_pkg::GENE_W-1:0]  rdata
);

   logic [gaeng_pkg::GENE_W-1:0] mem [gaeng_pkg::POP];
   logic [gaeng_pkg::POP-1:0]    vld_ff;
   logic [gaeng_pkg::GENE_W-1:0] q_ff;
   logic                         qv_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         q_ff <= mem[ctl.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         qv_ff  <= 1'b0;
      end else begin
         if (ctl.we) begin
            vld_ff[ctl.waddr] <= 1'b1;
         end
         if (ctl.re) begin
            qv_ff <= vld_ff[ctl.raddr];
         end
      end
   end

   assign rdata = qv_ff ? q_ff : '0;

endmodule

@@ bench/tb_roulette_ga_generation_engine_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_roulette_ga_generation_engine_top
// Self-checking bench for the GA generation engine. A queue of load, select,
// crossover and mutate items feeds a clocked driver. A behavioral shadow of
// the genome, parent and fitness stores predicts each result on accept. A
// clocked monitor checks results in order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_roulette_ga_generation_engine_top;

   localparam int unsigned SUM_MAX        = (1 << gaeng_pkg::SUM_W) - 1;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {DRAW_FIXED, DRAW_INSIDE, DRAW_EDGE, DRAW_BEYOND} draw_mode_type;

   typedef struct {
      logic [gaeng_pkg::KIND_W-1:0] kind;
      logic [gaeng_pkg::IDX_W-1:0]  slot;
      logic [gaeng_pkg::GENE_W-1:0] genome;
      logic [gaeng_pkg::FIT_W-1:0]  fit;
      logic [gaeng_pkg::DRAW_W-1:0] draw;
      draw_mode_type                draw_mode;
      logic [gaeng_pkg::CUT_W-1:0]  cut;
      logic [gaeng_pkg::GENE_W-1:0] mask;
   } ga_item_type;

   typedef struct packed {
      logic [gaeng_pkg::IDX_W-1:0]  picked;
      logic [gaeng_pkg::GENE_W-1:0] first;
      logic [gaeng_pkg::GENE_W-1:0] second;
      logic [gaeng_pkg::SUM_W-1:0]  sum;
      logic [gaeng_pkg::STAT_W-1:0] status;
   } ga_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [gaeng_pkg::KIND_W-1:0] req_type = '0;
   logic [gaeng_pkg::IDX_W-1:0]  req_slot_index = '0;
   logic [gaeng_pkg::GENE_W-1:0] req_genome_bits = '0;
   logic [gaeng_pkg::FIT_W-1:0]  req_fitness_value = '0;
   logic [gaeng_pkg::DRAW_W-1:0] req_wheel_draw = '0;
   logic [gaeng_pkg::CUT_W-1:0]  req_cut_point = '0;
   logic [gaeng_pkg::GENE_W-1:0] req_flip_mask = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [gaeng_pkg::IDX_W-1:0]  rsp_picked_index;
   logic [gaeng_pkg::GENE_W-1:0] rsp_genome_first;
   logic [gaeng_pkg::GENE_W-1:0] rsp_genome_second;
   logic [gaeng_pkg::SUM_W-1:0]  rsp_fitness_sum;
   logic [gaeng_pkg::STAT_W-1:0] rsp_status_code;

   // shadow population
   logic [gaeng_pkg::GENE_W-1:0] chrom_mem [gaeng_pkg::POP];
   logic [gaeng_pkg::GENE_W-1:0] parent_mem [gaeng_pkg::POP];
   logic [gaeng_pkg::FIT_W-1:0]  fit_mem [gaeng_pkg::POP];
   logic [gaeng_pkg::SUM_W-1:0]  fit_tally;

   ga_item_type   ga_item_q [$];
   ga_result_type step_outcomes_q [$];
   ga_item_type   sent_item;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            mismatch_count = 0;
   int            idle_cycles = 0;

   roulette_ga_generation_engine_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_slot_index    (req_slot_index),
      .req_genome_bits   (req_genome_bits),
      .req_fitness_value (req_fitness_value),
      .req_wheel_draw    (req_wheel_draw),
      .req_cut_point     (req_cut_point),
      .req_flip_mask     (req_flip_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_picked_index  (rsp_picked_index),
      .rsp_genome_first  (rsp_genome_first),
      .rsp_genome_second (rsp_genome_second),
      .rsp_fitness_sum   (rsp_fitness_sum),
      .rsp_status_code   (rsp_status_code)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic ga_result_type apply_ga_item(input ga_item_type it);
      ga_result_type                r;
      int unsigned                  acc;
      int unsigned                  cut;
      logic [gaeng_pkg::IDX_W-1:0]  pick;
      logic                         found;
      logic                         bad_index;
      logic [gaeng_pkg::GENE_W-1:0] keep;
      logic [gaeng_pkg::GENE_W-1:0] child_a;
      logic [gaeng_pkg::GENE_W-1:0] child_b;
      r = '0;
      if (it.kind == gaeng_pkg::KIND_CROSS) begin
         bad_index = (2 * int'(it.slot) + 1 >= gaeng_pkg::POP);
      end else begin
         bad_index = (int'(it.slot) >= gaeng_pkg::POP);
      end
      if (bad_index) begin
         r.status = gaeng_pkg::STAT_RANGE;
      end else begin
         case (it.kind)
            gaeng_pkg::KIND_LOAD: begin
               chrom_mem[it.slot] = it.genome;
               fit_mem[it.slot] = it.fit;
               acc = 0;
               for (int i = 0; i < gaeng_pkg::POP; i++) begin
                  acc += fit_mem[i];
                  if (acc > SUM_MAX) acc = SUM_MAX;
               end
               fit_tally = gaeng_pkg::SUM_W'(acc);
               r.first = it.genome;
            end
            gaeng_pkg::KIND_SELECT: begin
               acc = 0;
               pick = gaeng_pkg::LAST_IDX;
               found = 1'b0;
               for (int i = 0; i < gaeng_pkg::POP && !found; i++) begin
                  acc += fit_mem[i];
                  if (acc >= it.draw) begin
                     pick = gaeng_pkg::IDX_W'(i);
                     found = 1'b1;
                  end
               end
               r.status = found ? gaeng_pkg::STAT_OK : gaeng_pkg::STAT_DRAW;
               parent_mem[it.slot] = chrom_mem[pick];
               r.picked = pick;
               r.first = parent_mem[it.slot];
            end
            gaeng_pkg::KIND_CROSS: begin
               cut = (it.cut > gaeng_pkg::GENE_W) ? gaeng_pkg::GENE_W : it.cut;
               keep = (cut >= gaeng_pkg::GENE_W) ? '1
                                                 : gaeng_pkg::GENE_W'((32'd1 << cut) - 1);
               child_a = (parent_mem[2*it.slot] & keep) | (parent_mem[2*it.slot+1] & ~keep);
               child_b = (parent_mem[2*it.slot+1] & keep) | (parent_mem[2*it.slot] & ~keep);
               chrom_mem[2*it.slot] = child_a;
               chrom_mem[2*it.slot+1] = child_b;
               r.first = child_a;
               r.second = child_b;
            end
            default: begin
               chrom_mem[it.slot] = chrom_mem[it.slot] ^ it.mask;
               r.first = chrom_mem[it.slot];
            end
         endcase
      end
      r.sum = fit_tally;
      return r;
   endfunction

   function automatic ga_item_type mk_item(input logic [gaeng_pkg::KIND_W-1:0] kind,
                                           input logic [gaeng_pkg::IDX_W-1:0] slot,
                                           input logic [gaeng_pkg::GENE_W-1:0] genome,
                                           input logic [gaeng_pkg::FIT_W-1:0] fit,
                                           input logic [gaeng_pkg::DRAW_W-1:0] draw,
                                           input logic [gaeng_pkg::CUT_W-1:0] cut,
                                           input logic [gaeng_pkg::GENE_W-1:0] mask);
      ga_item_type it;
      it.kind = kind;
      it.slot = slot;
      it.genome = genome;
      it.fit = fit;
      it.draw = draw;
      it.draw_mode = DRAW_FIXED;
      it.cut = cut;
      it.mask = mask;
      return it;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (ga_item_q.size() != 0 || req_valid || step_outcomes_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_random_phase(input int n, input int send_pct, input int recv_pct);
      ga_item_type it;
      int          roll;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int j = 0; j < n; j++) begin
         roll = $urandom_range(99);
         it.kind = (roll < 25) ? gaeng_pkg::KIND_LOAD : (roll < 55) ? gaeng_pkg::KIND_SELECT :
                   (roll < 80) ? gaeng_pkg::KIND_CROSS : gaeng_pkg::KIND_MUTATE;
         it.slot = gaeng_pkg::IDX_W'($urandom_range(gaeng_pkg::POP - 1));
         // mostly in-range crossover pairs
         if (it.kind == gaeng_pkg::KIND_CROSS && $urandom_range(3) != 0) begin
            it.slot = gaeng_pkg::IDX_W'($urandom_range(gaeng_pkg::PAIR_LAST));
         end
         it.genome = gaeng_pkg::GENE_W'($urandom);
         case ($urandom_range(3))
            0: it.fit = '0;
            1: it.fit = '1;
            2: it.fit = gaeng_pkg::FIT_W'($urandom_range(300));
            default: it.fit = gaeng_pkg::FIT_W'($urandom);
         endcase
         it.draw = gaeng_pkg::DRAW_W'($urandom);
         roll = $urandom_range(9);
         if (roll < 4) begin
            it.draw_mode = DRAW_INSIDE;
         end else if (roll < 6) begin
            it.draw_mode = DRAW_EDGE;
         end else if (roll < 7) begin
            it.draw_mode = DRAW_BEYOND;
         end else begin
            it.draw_mode = DRAW_FIXED;
         end
         if ($urandom_range(99) < 85) begin
            it.cut = gaeng_pkg::CUT_W'($urandom_range(gaeng_pkg::GENE_W));
         end else begin
            it.cut = gaeng_pkg::CUT_W'($urandom_range(31, gaeng_pkg::GENE_W + 1));
         end
         it.mask = gaeng_pkg::GENE_W'($urandom);
         ga_item_q.push_back(it);
      end
      wait_drained();
   endtask

   // draws are resolved against the shadow total when the item is launched
   always @(posedge clock) begin : driver
      ga_item_type nxt;
      int unsigned cum;
      int unsigned upto;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            step_outcomes_q.push_back(apply_ga_item(sent_item));
         end
         if (!req_valid || req_ready) begin
            if (ga_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = ga_item_q.pop_front();
               case (nxt.draw_mode)
                  DRAW_INSIDE: nxt.draw = gaeng_pkg::DRAW_W'($urandom_range(fit_tally));
                  DRAW_EDGE: begin
                     upto = $urandom_range(gaeng_pkg::POP - 1);
                     cum = 0;
                     for (int i = 0; i <= upto; i++) cum += fit_mem[i];
                     nxt.draw = gaeng_pkg::DRAW_W'(cum);
                  end
                  DRAW_BEYOND: begin
                     cum = fit_tally + 1 + $urandom_range(15);
                     nxt.draw = gaeng_pkg::DRAW_W'((cum > SUM_MAX) ? SUM_MAX : cum);
                  end
                  default: ;
               endcase
               sent_item = nxt;
               req_type <= nxt.kind;
               req_slot_index <= nxt.slot;
               req_genome_bits <= nxt.genome;
               req_fitness_value <= nxt.fit;
               req_wheel_draw <= nxt.draw;
               req_cut_point <= nxt.cut;
               req_flip_mask <= nxt.mask;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      ga_result_type got;
      ga_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_picked_index, rsp_genome_first, rsp_genome_second,
                   rsp_fitness_sum, rsp_status_code};
            if (step_outcomes_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("%0t: unexpected result pick=%0d g1=%h g2=%h sum=%0d st=%0d",
                           $realtime, got.picked, got.first, got.second, got.sum, got.status);
               end
               mismatch_count++;
            end else begin
               want = step_outcomes_q.pop_front();
               if (got.picked !== want.picked || got.first !== want.first ||
                   got.second !== want.second || got.sum !== want.sum ||
                   got.status !== want.status) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("%0t: mismatch exp pick=%0d g1=%h g2=%h sum=%0d st=%0d",
                              $realtime, want.picked, want.first, want.second, want.sum,
                              want.status);
                     $display("%0t:          got pick=%0d g1=%h g2=%h sum=%0d st=%0d",
                              $realtime, got.picked, got.first, got.second, got.sum,
                              got.status);
                  end
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      for (int i = 0; i < gaeng_pkg::POP; i++) begin
         chrom_mem[i] = '0;
         parent_mem[i] = '0;
         fit_mem[i] = '0;
      end
      fit_tally = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty wheel: zero draw picks first, any other draw runs off the end
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd0, '1, '1, 20'd0, 5'd31, '1));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd15, '0, '0, 20'd1, 5'd0, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_LOAD, 4'd0, 16'hFFFF, 16'hFFFF, '1, 5'd16,
                                  '1));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_LOAD, 4'd15, 16'hA5A5, 16'h0000, '0, 5'd0,
                                  '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_LOAD, 4'd7, 16'h0000, 16'h0001, '0, 5'd0,
                                  '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_LOAD, 4'd3, 16'h1234, 16'h0000, '0, 5'd0,
                                  '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd0, '0, '0, 20'd0, 5'd0, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd1, '0, '0, 20'h0FFFF, 5'd0, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd1, '0, '0, 20'h10000, 5'd0, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd15, '0, '0, 20'hFFFFF, 5'd0, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd14, '0, '0, 20'h10001, 5'd0, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_CROSS, 4'd0, '0, '0, '0, 5'd0, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_CROSS, 4'd0, '0, '0, '0, 5'd16, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_CROSS, 4'd7, '0, '0, '0, 5'd8, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_CROSS, 4'd0, '0, '0, '0, 5'd31, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_CROSS, 4'd0, '0, '0, '0, 5'd17, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_CROSS, 4'd8, '1, '1, '1, 5'd4, '1));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_CROSS, 4'd15, '0, '0, '0, 5'd5, '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_MUTATE, 4'd0, '0, '0, '0, 5'd0, 16'hFFFF));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_MUTATE, 4'd15, '1, '1, '1, 5'd31, 16'h0000));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_MUTATE, 4'd9, '0, '0, '0, 5'd0, 16'h8001));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_LOAD, 4'd15, 16'h0000, 16'hFFFF, '0, 5'd0,
                                  '0));
      ga_item_q.push_back(mk_item(gaeng_pkg::KIND_SELECT, 4'd2, '0, '0, 20'h1FFFF, 5'd0, '0));
      wait_drained();

      run_random_phase(450, 15, 64);
      run_random_phase(450, 64, 15);
      run_random_phase(450, 0, 0);

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && step_outcomes_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
